>>> design/affine_2x3_inverse_checked_defines.svh
// assertion macros for the checked 2x3 affine inverse
// used by the top level only; expects clk and arst_n in the enclosing scope
`ifndef AFFINE_2X3_INVERSE_CHECKED_DEFINES_SVH
`define AFFINE_2X3_INVERSE_CHECKED_DEFINES_SVH
`ifndef SYNTH
`define AFF_ASSERT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("aff2x3: same-cycle check failed");
`define AFF_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("aff2x3: next-cycle check failed");
`else
`define AFF_ASSERT(lbl, ante, cons)
`define AFF_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> design/aff2x3_pkg.sv
// shared types and constants of the checked 2x3 affine inverse
// no dependencies; used by the interfaces, the divider lane and the top level
`default_nettype none

package aff2x3_pkg;

	localparam int WORD_W  = 32;
	localparam int CFG_W   = 31;
	localparam int QUO_W   = 32;
	// overflow check, one stage per quotient bit, rounding, range check
	localparam int DIV_LAT = QUO_W + 3;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic [CFG_W-1:0] bound_t;

	typedef enum logic {
		CFG_DET_MIN = 1'b0,
		CFG_DET_MAX = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic  valid;
		logic  ok;
	} tag_t;

	typedef struct packed {
		logic  accepted;
		word_t inv00;
		word_t inv01;
		word_t inv02;
		word_t inv10;
		word_t inv11;
		word_t inv12;
	} inv_res_t;

endpackage

`default_nettype wire

>>> design/aff2x3_mat_if.sv
// valid/ready channel carrying one 2x3 affine matrix per transaction
// depends on aff2x3_pkg for the element type
`default_nettype none

interface aff2x3_mat_if;
	logic                valid;
	logic                ready;
	aff2x3_pkg::word_t   m00;
	aff2x3_pkg::word_t   m01;
	aff2x3_pkg::word_t   m02;
	aff2x3_pkg::word_t   m10;
	aff2x3_pkg::word_t   m11;
	aff2x3_pkg::word_t   m12;

	modport source (output valid, output m00, output m01, output m02,
		output m10, output m11, output m12, input ready);
	modport sink (input valid, input m00, input m01, input m02,
		input m10, input m11, input m12, output ready);
endinterface

`default_nettype wire

>>> design/aff2x3_inv_if.sv
// valid/ready channel carrying one inverse result per transaction
// depends on aff2x3_pkg for the element type
`default_nettype none

interface aff2x3_inv_if;
	logic                valid;
	logic                ready;
	logic                accepted;
	aff2x3_pkg::word_t   inv00;
	aff2x3_pkg::word_t   inv01;
	aff2x3_pkg::word_t   inv02;
	aff2x3_pkg::word_t   inv10;
	aff2x3_pkg::word_t   inv11;
	aff2x3_pkg::word_t   inv12;

	modport source (output valid, output accepted, output inv00, output inv01,
		output inv02, output inv10, output inv11, output inv12, input ready);
	modport sink (input valid, input accepted, input inv00, input inv01,
		input inv02, input inv10, input inv11, input inv12, output ready);
endinterface

`default_nettype wire

>>> design/affine_2x3_inverse_checked.sv
// Checked inverse of a 2x3 affine warp in signed fixed point (FRAC_BITS fraction bits).
// Channels: matrix (sink) takes m00..m12 per transaction; inverse (source) returns
// accepted and inv00..inv12, all zero when the matrix is rejected.
// Configuration: cfg_we writes cfg_wdata into det_min or det_max, chosen by cfg_idx;
// write only while no transaction is in flight.
// Throughput: one matrix per cycle while matrix.ready is high. The result passes through
// multipliers, determinant, bound check, then a divider lane per inverse element with
// one quotient bit per stage, rounding and range check, and the output register.
// Stall: the pipeline advances as a whole; when the receiver holds off, one more
// result parks in a skid register and the pipeline then freezes, ready going low
// until the skid register drains. Nothing is lost or repeated.
// Reset (arst_n low) empties the pipeline and sets det_min to 1 and det_max to all
// ones; matrix.ready is high from the first cycle after reset.
// depends on aff2x3_pkg, aff2x3_mat_if, aff2x3_inv_if, aff2x3_div and the defines header
`default_nettype none
`include "affine_2x3_inverse_checked_defines.svh"

module affine_2x3_inverse_checked #(
	parameter int FRAC_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  aff2x3_pkg::cfg_idx_t    cfg_idx,
	input  aff2x3_pkg::bound_t      cfg_wdata,
	aff2x3_mat_if.sink              matrix,
	aff2x3_inv_if.source            inverse
);

	localparam int WORD_W = aff2x3_pkg::WORD_W;
	localparam int PROD_W = 2 * WORD_W;
	localparam int DIFF_W = PROD_W + 1;
	localparam int DEN_W  = aff2x3_pkg::CFG_W + FRAC_BITS;
	localparam int LIN_SH = 2 * FRAC_BITS;
	localparam int LAT    = aff2x3_pkg::DIV_LAT;

	// configuration
	aff2x3_pkg::bound_t det_min_q;
	aff2x3_pkg::bound_t det_max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			det_min_q <= aff2x3_pkg::bound_t'(1);
			det_max_q <= '1;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				aff2x3_pkg::CFG_DET_MIN: det_min_q <= cfg_wdata;
				aff2x3_pkg::CFG_DET_MAX: det_max_q <= cfg_wdata;
			endcase
		end
	end

	// pipeline advance, held while the skid register is occupied
	logic en;
	logic skid_valid_q;
	logic out_valid_q;

	assign en           = ~skid_valid_q;
	assign matrix.ready = en;

	// stage 1: products
	logic                       valid_s1;
	logic signed [PROD_W-1:0]   p_ae_s1, p_bd_s1, p_bf_s1, p_ec_s1, p_dc_s1, p_af_s1;
	aff2x3_pkg::word_t          a_s1, b_s1, d_s1, e_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else if (en) valid_s1 <= matrix.valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_ae_s1 <= matrix.m00 * matrix.m11;
			p_bd_s1 <= matrix.m01 * matrix.m10;
			p_bf_s1 <= matrix.m01 * matrix.m12;
			p_ec_s1 <= matrix.m11 * matrix.m02;
			p_dc_s1 <= matrix.m10 * matrix.m02;
			p_af_s1 <= matrix.m00 * matrix.m12;
			a_s1    <= matrix.m00;
			b_s1    <= matrix.m01;
			d_s1    <= matrix.m10;
			e_s1    <= matrix.m11;
		end
	end

	// stage 2: determinant and translation numerators
	logic                       valid_s2;
	logic signed [DIFF_W-1:0]   det_s2, t02_s2, t12_s2;
	aff2x3_pkg::word_t          a_s2, b_s2, d_s2, e_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s2 <= 1'b0;
		else if (en) valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			det_s2 <= DIFF_W'(p_ae_s1) - DIFF_W'(p_bd_s1);
			t02_s2 <= DIFF_W'(p_bf_s1) - DIFF_W'(p_ec_s1);
			t12_s2 <= DIFF_W'(p_dc_s1) - DIFF_W'(p_af_s1);
			a_s2   <= a_s1;
			b_s2   <= b_s1;
			d_s2   <= d_s1;
			e_s2   <= e_s1;
		end
	end

	// stage 3: bound check, magnitudes and signs
	logic [DIFF_W-1:0] lo_bnd, hi_bnd, det_u, t02_abs, t12_abs;
	logic              det_ok;

	assign lo_bnd  = DIFF_W'({det_min_q, {FRAC_BITS{1'b0}}});
	assign hi_bnd  = DIFF_W'({det_max_q, {FRAC_BITS{1'b0}}});
	assign det_u   = det_s2;
	assign det_ok  = ~det_s2[DIFF_W-1] && (det_u != '0) && (det_u >= lo_bnd)
		&& (det_u <= hi_bnd);
	assign t02_abs = t02_s2[DIFF_W-1] ? -t02_s2 : t02_s2;
	assign t12_abs = t12_s2[DIFF_W-1] ? -t12_s2 : t12_s2;

	logic                valid_s3, ok_s3;
	logic [DEN_W-1:0]    den_s3;
	logic [WORD_W-1:0]   mag_a_s3, mag_b_s3, mag_d_s3, mag_e_s3;
	logic                neg_a_s3, neg_b_s3, neg_d_s3, neg_e_s3;
	logic [PROD_W-1:0]   mag_t02_s3, mag_t12_s3;
	logic                neg_t02_s3, neg_t12_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s3 <= 1'b0;
		else if (en) valid_s3 <= valid_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s3      <= det_ok;
			den_s3     <= det_s2[DEN_W-1:0];
			mag_a_s3   <= a_s2[WORD_W-1] ? WORD_W'(-a_s2) : WORD_W'(a_s2);
			mag_b_s3   <= b_s2[WORD_W-1] ? WORD_W'(-b_s2) : WORD_W'(b_s2);
			mag_d_s3   <= d_s2[WORD_W-1] ? WORD_W'(-d_s2) : WORD_W'(d_s2);
			mag_e_s3   <= e_s2[WORD_W-1] ? WORD_W'(-e_s2) : WORD_W'(e_s2);
			neg_a_s3   <= a_s2[WORD_W-1];
			neg_b_s3   <= ~b_s2[WORD_W-1];
			neg_d_s3   <= ~d_s2[WORD_W-1];
			neg_e_s3   <= e_s2[WORD_W-1];
			mag_t02_s3 <= t02_abs[PROD_W-1:0];
			mag_t12_s3 <= t12_abs[PROD_W-1:0];
			neg_t02_s3 <= t02_s2[DIFF_W-1];
			neg_t12_s3 <= t12_s2[DIFF_W-1];
		end
	end

	// divider lanes
	aff2x3_pkg::word_t res00, res01, res02, res10, res11, res12;
	logic              fail00, fail01, fail02, fail10, fail11, fail12;

	aff2x3_div #(.NUM_W(WORD_W), .SHIFT(LIN_SH), .DEN_W(DEN_W)) u_div00 (
		.clk(clk), .en(en), .mag(mag_e_s3), .neg(neg_e_s3), .den(den_s3),
		.res(res00), .fail(fail00)
	);

	aff2x3_div #(.NUM_W(WORD_W), .SHIFT(LIN_SH), .DEN_W(DEN_W)) u_div01 (
		.clk(clk), .en(en), .mag(mag_b_s3), .neg(neg_b_s3), .den(den_s3),
		.res(res01), .fail(fail01)
	);

	aff2x3_div #(.NUM_W(PROD_W), .SHIFT(FRAC_BITS), .DEN_W(DEN_W)) u_div02 (
		.clk(clk), .en(en), .mag(mag_t02_s3), .neg(neg_t02_s3), .den(den_s3),
		.res(res02), .fail(fail02)
	);

	aff2x3_div #(.NUM_W(WORD_W), .SHIFT(LIN_SH), .DEN_W(DEN_W)) u_div10 (
		.clk(clk), .en(en), .mag(mag_d_s3), .neg(neg_d_s3), .den(den_s3),
		.res(res10), .fail(fail10)
	);

	aff2x3_div #(.NUM_W(WORD_W), .SHIFT(LIN_SH), .DEN_W(DEN_W)) u_div11 (
		.clk(clk), .en(en), .mag(mag_a_s3), .neg(neg_a_s3), .den(den_s3),
		.res(res11), .fail(fail11)
	);

	aff2x3_div #(.NUM_W(PROD_W), .SHIFT(FRAC_BITS), .DEN_W(DEN_W)) u_div12 (
		.clk(clk), .en(en), .mag(mag_t12_s3), .neg(neg_t12_s3), .den(den_s3),
		.res(res12), .fail(fail12)
	);

	// valid and bound verdict travelling beside the divider lanes
	aff2x3_pkg::tag_t tag_s [0:LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LAT; k++) tag_s[k] <= '0;
		end else if (en) begin
			tag_s[0] <= '{valid: valid_s3, ok: ok_s3};
			for (int k = 1; k < LAT; k++) tag_s[k] <= tag_s[k-1];
		end
	end

	// result assembly
	logic                 fin_valid, fin_ok;
	aff2x3_pkg::inv_res_t fin_res;

	assign fin_valid = tag_s[LAT-1].valid;
	assign fin_ok    = tag_s[LAT-1].ok && ~(fail00 || fail01 || fail02
		|| fail10 || fail11 || fail12);

	always_comb begin
		fin_res          = '0;
		fin_res.accepted = fin_ok;
		if (fin_ok) begin
			fin_res.inv00 = res00;
			fin_res.inv01 = res01;
			fin_res.inv02 = res02;
			fin_res.inv10 = res10;
			fin_res.inv11 = res11;
			fin_res.inv12 = res12;
		end
	end

	// output register with skid
	aff2x3_pkg::inv_res_t out_q, skid_q;
	logic                 push, pop;

	assign push = en && fin_valid;
	assign pop  = out_valid_q && inverse.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q  <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q  <= 1'b1;
			skid_valid_q <= out_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && skid_valid_q) out_q <= skid_q;
		else if (push && (~out_valid_q || pop)) out_q <= fin_res;
		if (push && out_valid_q && ~pop) skid_q <= fin_res;
	end

	assign inverse.valid    = out_valid_q;
	assign inverse.accepted = out_q.accepted;
	assign inverse.inv00    = out_q.inv00;
	assign inverse.inv01    = out_q.inv01;
	assign inverse.inv02    = out_q.inv02;
	assign inverse.inv10    = out_q.inv10;
	assign inverse.inv11    = out_q.inv11;
	assign inverse.inv12    = out_q.inv12;

	// checks
	`AFF_ASSERT(a_skid_behind_out, skid_valid_q, out_valid_q)
	`AFF_ASSERT(a_skid_fill_on_stall, $rose(skid_valid_q), $past(out_valid_q && !inverse.ready))
	`AFF_ASSERT_NXT(a_skid_drains, skid_valid_q && inverse.ready, !skid_valid_q)
	`AFF_ASSERT(a_reject_zero, out_valid_q && !out_q.accepted, out_q.inv00 == '0 && out_q.inv01 == '0 && out_q.inv02 == '0 && out_q.inv10 == '0 && out_q.inv11 == '0 && out_q.inv12 == '0)

endmodule

`default_nettype wire

>>> design/aff2x3_div.sv
// pipelined restoring divider lane: round(+-mag * 2^SHIFT / den), ties away from zero
// one quotient bit per stage; depends on aff2x3_pkg
`default_nettype none

module aff2x3_div #(
	parameter int NUM_W = 32,
	parameter int SHIFT = 32,
	parameter int DEN_W = 47
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic [NUM_W-1:0]     mag,
	input  logic                 neg,
	input  logic [DEN_W-1:0]     den,
	output aff2x3_pkg::word_t    res,
	output logic                 fail
);

	localparam int QW    = aff2x3_pkg::QUO_W;
	localparam int N_W   = NUM_W + SHIFT;
	localparam int HI_W  = N_W - QW;
	localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;
	localparam logic [QW:0] LIM_NEG = {2'b01, {(QW-1){1'b0}}};
	localparam logic [QW:0] LIM_POS = LIM_NEG - 1'b1;

	logic [N_W-1:0]   num;
	logic [CMP_W-1:0] hi_ext;

	assign num    = {mag, {SHIFT{1'b0}}};
	assign hi_ext = CMP_W'(num[N_W-1:QW]);

	// remainder, low numerator bits shifting out while quotient bits shift in
	logic [DEN_W-1:0] rem_s [0:QW];
	logic [QW-1:0]    lq_s  [0:QW];
	logic [DEN_W-1:0] den_s [0:QW];
	logic             neg_s [0:QW];
	logic             big_s [0:QW];

	// quotient would need more than QW bits
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= hi_ext[DEN_W-1:0];
			lq_s[0]  <= num[QW-1:0];
			den_s[0] <= den;
			neg_s[0] <= neg;
			big_s[0] <= hi_ext >= CMP_W'(den);
		end
	end

	for (genvar j = 0; j < QW; j++) begin : g_step
		logic [DEN_W:0] trial;
		logic [DEN_W:0] diff;

		assign trial = {rem_s[j], lq_s[j][QW-1]};
		assign diff  = trial - {1'b0, den_s[j]};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1] <= diff[DEN_W] ? trial[DEN_W-1:0] : diff[DEN_W-1:0];
				lq_s[j+1]  <= {lq_s[j][QW-2:0], ~diff[DEN_W]};
				den_s[j+1] <= den_s[j];
				neg_s[j+1] <= neg_s[j];
				big_s[j+1] <= big_s[j];
			end
		end
	end

	// rounding decision
	logic [QW-1:0] quo_s33;
	logic          rnd_s33;
	logic          neg_s33;
	logic          big_s33;

	always_ff @(posedge clk) begin
		if (en) begin
			quo_s33 <= lq_s[QW];
			rnd_s33 <= {rem_s[QW], 1'b0} >= {1'b0, den_s[QW]};
			neg_s33 <= neg_s[QW];
			big_s33 <= big_s[QW];
		end
	end

	// round, range check, apply sign
	logic [QW:0] q_sum;
	logic        over;

	assign q_sum = {1'b0, quo_s33} + (QW+1)'(rnd_s33);
	assign over  = neg_s33 ? (q_sum > LIM_NEG) : (q_sum > LIM_POS);

	aff2x3_pkg::word_t res_s34;
	logic              fail_s34;

	always_ff @(posedge clk) begin
		if (en) begin
			res_s34  <= neg_s33 ? aff2x3_pkg::word_t'(-q_sum[QW-1:0])
				: aff2x3_pkg::word_t'(q_sum[QW-1:0]);
			fail_s34 <= big_s33 || over;
		end
	end

	assign res  = res_s34;
	assign fail = fail_s34;

endmodule

`default_nettype wire
